FILE: rtl/u8esc_pkg.sv
// Shared types, constants and helpers for the UTF-8 to escape decoder.
`timescale 1ns / 1ps

package u8esc_pkg;

  // Job queue between the front and the back end.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam int CPW = 21;

  // ASCII characters the block emits.
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_UP_U   = 8'h55;
  localparam logic [7:0] CH_QMARK  = 8'h3f;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LOW_A  = 8'h61;

  // Input byte class boundaries.
  localparam logic [7:0] LIM_ASCII = 8'h80;
  localparam logic [7:0] LIM_LEAD2 = 8'hc2;
  localparam logic [7:0] LIM_LEAD3 = 8'he0;
  localparam logic [7:0] LIM_LEAD4 = 8'hf0;
  localparam logic [7:0] LIM_BAD   = 8'hf8;

  // Last byte index of each job kind.
  localparam logic [3:0] LAST_IDX_LIT   = 4'd0;
  localparam logic [3:0] LAST_IDX_SHORT = 4'd5;
  localparam logic [3:0] LAST_IDX_LONG  = 4'd9;

  typedef enum logic [1:0] {
    KIND_LIT,
    KIND_SHORT,
    KIND_LONG
  } kind_t;

  typedef struct packed {
    kind_t          kind;
    logic [CPW-1:0] data;
  } job_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] d;
    if (nib < 4'd10) begin
      d = CH_ZERO + {4'd0, nib};
    end else begin
      d = CH_LOW_A + {4'd0, nib} - 8'd10;
    end
    return d;
  endfunction

endpackage

FILE: rtl/u8esc_front.sv
// Front end: accepts UTF-8 bytes, tracks sequences and issues output jobs.
`timescale 1ns / 1ps

module u8esc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic [7:0]        in_byte,
  input  logic              end_of_data,
  output logic              job_valid,
  output u8esc_pkg::job_t   job
);

  logic [1:0]                bytes_remaining;
  logic                      long_form;
  logic [u8esc_pkg::CPW-1:0] code_point;

  logic [1:0]                bytes_remaining_next;
  logic                      long_form_next;
  logic [u8esc_pkg::CPW-1:0] code_point_next;
  logic [u8esc_pkg::CPW-1:0] cp_shifted;

  assign cp_shifted = {code_point[u8esc_pkg::CPW-7:0], in_byte[5:0]};

  always_comb begin
    bytes_remaining_next = bytes_remaining;
    long_form_next       = long_form;
    code_point_next      = code_point;
    job_valid            = 1'b0;
    job.kind             = u8esc_pkg::KIND_LIT;
    job.data             = {{(u8esc_pkg::CPW-8){1'b0}}, in_byte};
    if (in_fire) begin
      if (bytes_remaining == 2'd0) begin
        priority if (in_byte < u8esc_pkg::LIM_ASCII) begin
          job_valid = 1'b1;
        end else if (in_byte < u8esc_pkg::LIM_LEAD2) begin
          job_valid = 1'b1;
          job.data  = {{(u8esc_pkg::CPW-8){1'b0}}, u8esc_pkg::CH_QMARK};
        end else if (in_byte < u8esc_pkg::LIM_LEAD3) begin
          code_point_next      = {{(u8esc_pkg::CPW-5){1'b0}}, in_byte[4:0]};
          bytes_remaining_next = 2'd1;
          long_form_next       = 1'b0;
        end else if (in_byte < u8esc_pkg::LIM_LEAD4) begin
          code_point_next      = {{(u8esc_pkg::CPW-4){1'b0}}, in_byte[3:0]};
          bytes_remaining_next = 2'd2;
          long_form_next       = 1'b0;
        end else if (in_byte < u8esc_pkg::LIM_BAD) begin
          code_point_next      = {{(u8esc_pkg::CPW-3){1'b0}}, in_byte[2:0]};
          bytes_remaining_next = 2'd3;
          long_form_next       = 1'b1;
        end else begin
          job_valid = 1'b1;
          job.data  = {{(u8esc_pkg::CPW-8){1'b0}}, u8esc_pkg::CH_QMARK};
        end
      end else begin
        // Any byte inside a sequence counts as a continuation byte.
        code_point_next      = cp_shifted;
        bytes_remaining_next = bytes_remaining - 2'd1;
        if (bytes_remaining == 2'd1) begin
          job_valid            = 1'b1;
          job.kind             = long_form ? u8esc_pkg::KIND_LONG : u8esc_pkg::KIND_SHORT;
          job.data             = cp_shifted;
          long_form_next       = 1'b0;
          code_point_next      = '0;
        end
      end
      if (end_of_data) begin
        bytes_remaining_next = 2'd0;
        long_form_next       = 1'b0;
        code_point_next      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= 2'd0;
      long_form       <= 1'b0;
      code_point      <= '0;
    end else begin
      bytes_remaining <= bytes_remaining_next;
      long_form       <= long_form_next;
      code_point      <= code_point_next;
    end
  end

endmodule

FILE: rtl/u8esc_queue.sv
// Short job queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module u8esc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  u8esc_pkg::job_t wr_job,
  output logic            full,
  input  logic            rd_en,
  output logic            rd_valid,
  output u8esc_pkg::job_t rd_job
);

  u8esc_pkg::job_t             slots [u8esc_pkg::QDEPTH];
  logic [u8esc_pkg::QAW-1:0]   wr_ptr;
  logic [u8esc_pkg::QAW-1:0]   rd_ptr;
  logic [u8esc_pkg::QCW-1:0]   count;

  assign full     = (count == u8esc_pkg::QCW'(u8esc_pkg::QDEPTH));
  assign rd_valid = (count != '0);
  assign rd_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/u8esc_back.sv
// Back end: expands each job into output bytes held in an output register.
`timescale 1ns / 1ps

module u8esc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  input  u8esc_pkg::job_t job,
  output logic            job_done,
  input  logic            pop,
  output logic            empty,
  output logic [7:0]      out_byte,
  output logic            last
);

  logic       out_valid;
  logic [3:0] idx;
  logic [3:0] idx_next;
  logic [3:0] last_idx;
  logic [3:0] nib_pos;
  logic [3:0] nibble;
  logic [31:0] cp_wide;
  logic [7:0] byte_sel;
  logic       load;
  logic       is_last;

  assign empty   = !out_valid;
  assign load    = job_valid && (!out_valid || pop);
  assign is_last = (idx == last_idx);
  assign job_done = load && is_last;
  // The long form prints eight digits, so the top two nibbles read as zero.
  assign cp_wide = {{(32-u8esc_pkg::CPW){1'b0}}, job.data};

  always_comb begin
    unique case (job.kind)
      u8esc_pkg::KIND_SHORT: begin
        last_idx = u8esc_pkg::LAST_IDX_SHORT;
        nib_pos  = u8esc_pkg::LAST_IDX_SHORT - idx;
      end
      u8esc_pkg::KIND_LONG: begin
        last_idx = u8esc_pkg::LAST_IDX_LONG;
        nib_pos  = u8esc_pkg::LAST_IDX_LONG - idx;
      end
      default: begin
        last_idx = u8esc_pkg::LAST_IDX_LIT;
        nib_pos  = 4'd0;
      end
    endcase
  end

  assign nibble = cp_wide[{nib_pos[2:0], 2'b00} +: 4];

  always_comb begin
    if (job.kind == u8esc_pkg::KIND_LIT) begin
      byte_sel = job.data[7:0];
    end else begin
      priority if (idx == 4'd0) begin
        byte_sel = u8esc_pkg::CH_BSLASH;
      end else if (idx == 4'd1) begin
        byte_sel = (job.kind == u8esc_pkg::KIND_LONG) ? u8esc_pkg::CH_UP_U
                                                      : u8esc_pkg::CH_LOW_U;
      end else begin
        byte_sel = u8esc_pkg::hex_digit(nibble);
      end
    end
  end

  assign idx_next = is_last ? 4'd0 : idx + 4'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 4'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= idx_next;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= byte_sel;
      last     <= is_last;
    end
  end

endmodule

FILE: rtl/utf8_to_unicode_escape_decoder.sv
// Top level of the UTF-8 to backslash-u escape decoder.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------
//  input   | in        | push / full           | in_byte, end_of_data
//  result  | out       | pop / empty           | out_byte, last
//
// A byte is taken whenever the four-entry job queue has room. The back end
// emits one result byte per cycle while jobs wait and pop is high; a literal
// or '?' is one byte, a short escape six and a long escape ten, so the output
// register sets the sustained rate. Synchronous reset empties the queue and
// the output register and returns the sequence state to idle. Input and
// output stall independently; full rises only when the queue holds four jobs.
`timescale 1ns / 1ps

module utf8_to_unicode_escape_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       end_of_data,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       last
);

  logic            in_fire;
  logic            fe_job_valid;
  u8esc_pkg::job_t fe_job;
  logic            q_valid;
  u8esc_pkg::job_t q_job;
  logic            q_pop;

  assign in_fire = push && !full;

  u8esc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_fire     (in_fire),
    .in_byte     (in_byte),
    .end_of_data (end_of_data),
    .job_valid   (fe_job_valid),
    .job         (fe_job)
  );

  u8esc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (fe_job_valid),
    .wr_job   (fe_job),
    .full     (full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_job   (q_job)
  );

  u8esc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job       (q_job),
    .job_done  (q_pop),
    .pop       (pop),
    .empty     (empty),
    .out_byte  (out_byte),
    .last      (last)
  );

endmodule

FILE: rtl/u8esc_checker.sv
// Port-level checks for the decoder, bound to the top level.
`timescale 1ns / 1ps

module u8esc_checker (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic [7:0] in_byte,
  input logic       end_of_data,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       last
);

  // Reset leaves no result waiting and the input open.
  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("result or full flag survived reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(last)))
    else $error("waiting result changed before it was taken");

  // Inside an escape, a backslash is followed at once by the u or U marker.
  a_escape_marker: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && out_byte == 8'h5c && !last) |=>
      (!empty && (out_byte == 8'h75 || out_byte == 8'h55)))
    else $error("escape marker missing after backslash");

  // Only escape characters can be non-final bytes of a transaction.
  a_mid_bytes: assert property (@(posedge clk) disable iff (rst)
    (!empty && !last) |->
      (out_byte == 8'h5c || out_byte == 8'h75 || out_byte == 8'h55 ||
       (out_byte >= 8'h30 && out_byte <= 8'h39) ||
       (out_byte >= 8'h61 && out_byte <= 8'h66)))
    else $error("unexpected byte inside an escape");

endmodule

bind utf8_to_unicode_escape_decoder u8esc_checker u_checker (.*);
